/* hw/rtl/lsf_pkg.sv */
package lsf_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int LINE_LIMIT_DEF  = 1023;
    localparam int PATTERN_SLOTS   = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

    localparam logic [9:0]  LEN_FIELD_MAX = 10'd1023;
    localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_EOF  = 1'b1;

    localparam logic KIND_LINE  = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    localparam logic [2:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [2:0] REG_PATTERN_LOW    = 3'd1;
    localparam logic [2:0] REG_PATTERN_HIGH   = 3'd2;
    localparam logic [2:0] REG_IGNORE_CASE    = 3'd3;
    localparam logic [2:0] REG_INVERT_MATCH   = 3'd4;

    typedef struct packed {
        logic [4:0]   pattern_length;
        logic [127:0] pattern;
        logic         ignore_case;
        logic         invert_match;
    } cfg_t;

    // line end or end of file, as handed from front to back
    typedef struct packed {
        logic       is_eof;
        logic       has_line;
        logic       sel;
        logic [9:0] length;
        logic       split;
    } line_event_t;

    typedef struct packed {
        logic        record_kind;
        logic        selected;
        logic [31:0] line_number;
        logic [9:0]  line_length;
        logic        split_by_limit;
        logic [31:0] hit_count;
        logic        is_last;
    } record_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic ic);
        logic [7:0] r;
        r = b;
        if (ic && (b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z))
        begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/lsf_front.sv */
module lsf_front #(
    parameter int MAX_PATTERN = lsf_pkg::MAX_PATTERN_DEF,
    parameter int LINE_LIMIT  = lsf_pkg::LINE_LIMIT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lsf_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  logic [7:0]        data_byte,
    input  logic              queue_full,
    output logic              push,
    output lsf_pkg::line_event_t ev
);
    import lsf_pkg::*;

    localparam int CW = $clog2(LINE_LIMIT + 1);
    localparam int XW = (CW > 5) ? CW : 5;
    localparam int LW = (CW > 10) ? CW : 10;

    logic [7:0]    win_reg [MAX_PATTERN];
    logic [7:0]    win_next [MAX_PATTERN];
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          found_reg;
    logic          found_next;
    logic          zero_reg;
    logic          zero_next;

    logic          accept;
    logic [4:0]    plen;
    logic          window_match;
    logic          line_end;
    logic [CW-1:0] len_src;
    logic [LW-1:0] len_ext;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic [4:0] idx;
        logic [6:0] base;
        plen = (cfg.pattern_length > 5'(MAX_PATTERN)) ? 5'(MAX_PATTERN) : cfg.pattern_length;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (j == 0)
            begin
                win_next[j] = data_byte;
            end
            else
            begin
                win_next[j] = win_reg[j-1];
            end
        end
        window_match = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            idx  = 5'(plen - 5'(j) - 5'd1);
            base = {idx[3:0], 3'b000};
            if (5'(j) < plen)
            begin
                if (fold_byte(win_next[j], cfg.ignore_case)
                    != fold_byte(cfg.pattern[base +: 8], cfg.ignore_case))
                begin
                    window_match = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        cnt_next  = (cnt_reg < CW'(LINE_LIMIT)) ? cnt_reg + CW'(1) : cnt_reg;
        zero_next = zero_reg || (data_byte == CHAR_NUL);
        found_next = found_reg;
        if (plen == 5'd0)
        begin
            found_next = 1'b1;
        end
        else if (!zero_next && (XW'(cnt_next) >= XW'(plen)) && window_match)
        begin
            found_next = 1'b1;
        end
        line_end = (data_byte == CHAR_NEWLINE) || (cnt_next >= CW'(LINE_LIMIT));
    end

    always_comb
    begin
        len_src = (command == CMD_EOF) ? cnt_reg : cnt_next;
        len_ext = LW'(len_src);
        ev.is_eof   = (command == CMD_EOF);
        ev.has_line = (command == CMD_EOF) ? (cnt_reg != '0) : 1'b1;
        ev.length   = (len_ext > LW'(LEN_FIELD_MAX)) ? LEN_FIELD_MAX : len_ext[9:0];
        if (command == CMD_EOF)
        begin
            ev.sel   = (found_reg || (cfg.pattern_length == 5'd0)) ^ cfg.invert_match;
            ev.split = 1'b0;
        end
        else
        begin
            ev.sel   = found_next ^ cfg.invert_match;
            ev.split = (data_byte != CHAR_NEWLINE);
        end
        push = accept && ((command == CMD_EOF) || line_end);
    end

    always_ff @(posedge clk)
    begin
        if (accept && (command == CMD_DATA))
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                win_reg[j] <= win_next[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            zero_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if ((command == CMD_EOF) || line_end)
            begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
                zero_reg  <= 1'b0;
            end
            else
            begin
                cnt_reg   <= cnt_next;
                found_reg <= found_next;
                zero_reg  <= zero_next;
            end
        end
    end

endmodule

/* hw/rtl/lsf_queue.sv */
module lsf_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lsf_pkg::line_event_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output lsf_pkg::line_event_t head
);
    import lsf_pkg::*;

    line_event_t         mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (QUEUE_AW + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (QUEUE_AW + 1)'(1);
            end
        end
    end

endmodule

/* hw/rtl/lsf_back.sv */
module lsf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 queue_empty,
    input  lsf_pkg::line_event_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lsf_pkg::record_t     rec
);
    import lsf_pkg::*;

    logic        out_valid_reg;
    record_t     rec_reg;
    record_t     rec_next;
    logic [31:0] lines_reg;
    logic [31:0] lines_next;
    logic [31:0] hits_reg;
    logic [31:0] hits_next;
    logic        tail_reg;
    logic        tail_next;
    logic        load;
    logic        do_line;
    logic [31:0] lines_inc;

    assign out_valid = out_valid_reg;
    assign rec       = rec_reg;
    assign load      = !queue_empty && (!out_valid_reg || out_ready);
    // an end of file after a partial line gives the line record first
    assign do_line   = !head.is_eof || (head.has_line && !tail_reg);
    assign pop       = load && !(head.is_eof && do_line);
    assign lines_inc = (lines_reg == COUNT_MAX) ? lines_reg : lines_reg + 32'd1;

    always_comb
    begin
        rec_next   = '0;
        lines_next = lines_reg;
        hits_next  = hits_reg;
        tail_next  = tail_reg;
        if (do_line)
        begin
            lines_next             = lines_inc;
            rec_next.record_kind    = KIND_LINE;
            rec_next.selected       = head.sel;
            rec_next.line_number    = lines_inc;
            rec_next.line_length    = head.length;
            rec_next.split_by_limit = head.split;
            rec_next.is_last        = !head.is_eof;
            if (head.sel && (hits_reg != COUNT_MAX))
            begin
                hits_next = hits_reg + 32'd1;
            end
            tail_next = head.is_eof;
        end
        else
        begin
            rec_next.record_kind = KIND_COUNT;
            rec_next.hit_count   = hits_reg;
            rec_next.is_last     = 1'b1;
            lines_next           = '0;
            hits_next            = '0;
            tail_next            = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            lines_reg     <= '0;
            hits_reg      <= '0;
            tail_reg      <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                lines_reg     <= lines_next;
                hits_reg      <= hits_next;
                tail_reg      <= tail_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/line_substring_filter.sv */
// Channel  Dir  Handshake                 Payload
// s_*      in   s_tvalid / s_tready       text byte or end of file
// m_*      out  m_tvalid / m_tready       line verdict or file hit count
// cfg_*    in   cfg_valid / cfg_ready     register index and write data
//
// One byte per cycle while the event queue is not full; the window compare against
// the pattern is one parallel stage. A line end reaches m_* via the event queue and
// the output record register; end of file after a partial line gives two records,
// the line record first. rst_n zeroes counters, line state, queue pointers and
// configuration. A four-entry event queue lets input continue while m_tready is low.
module line_substring_filter #(
    parameter int MAX_PATTERN = lsf_pkg::MAX_PATTERN_DEF,
    parameter int LINE_LIMIT  = lsf_pkg::LINE_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic        s_tuser,    // command
    output logic        m_tvalid,
    input  logic        m_tready,
    // selected, line_number, line_length, split_by_limit, hit_count, zero fill
    output logic [79:0] m_tdata,
    output logic        m_tuser,    // record_kind
    output logic        m_tlast,    // is_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import lsf_pkg::*;

    cfg_t        cfg_reg;
    logic        push;
    line_event_t ev;
    logic        queue_full;
    logic        queue_empty;
    logic        pop;
    line_event_t head;
    record_t     rec;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: cfg_reg.pattern_length <= cfg_data[4:0];
                REG_PATTERN_LOW:    cfg_reg.pattern[63:0] <= cfg_data;
                REG_PATTERN_HIGH:   cfg_reg.pattern[127:64] <= cfg_data;
                REG_IGNORE_CASE:    cfg_reg.ignore_case <= cfg_data[0];
                REG_INVERT_MATCH:   cfg_reg.invert_match <= cfg_data[0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    lsf_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .LINE_LIMIT  (LINE_LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .command    (s_tuser),
        .data_byte  (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .ev         (ev)
    );

    lsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (ev),
        .full      (queue_full),
        .pop       (pop),
        .empty     (queue_empty),
        .head      (head)
    );

    lsf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .rec         (rec)
    );

    assign m_tdata = {4'b0000, rec.hit_count, rec.split_by_limit, rec.line_length,
                      rec.line_number, rec.selected};
    assign m_tuser = rec.record_kind;
    assign m_tlast = rec.is_last;

endmodule

/* tb/tb_top.sv */
module tb_top;
    import lsf_pkg::*;

    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 40;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 500000;

    class lsf_scoreboard;
        logic [4:0]   pat_len;
        logic [127:0] pattern;
        logic         fold_on;
        logic         invert_on;

        logic [7:0]   window [16];
        int           line_bytes;
        logic [31:0]  line_count;
        logic [31:0]  hit_total;
        logic         found;
        logic         nul_seen;

        record_t      expected_records[$];
        int           errors;
        int           records_checked;

        function new();
            pat_len         = '0;
            pattern         = '0;
            fold_on         = 1'b0;
            invert_on       = 1'b0;
            line_count      = '0;
            hit_total       = '0;
            errors          = 0;
            records_checked = 0;
            clear_line();
        endfunction

        function void clear_line();
            foreach (window[i])
                window[i] = '0;
            line_bytes = 0;
            found      = 1'b0;
            nul_seen   = 1'b0;
        endfunction

        function void set_reg(logic [2:0] index, logic [63:0] value);
            unique case (index)
                REG_PATTERN_LENGTH: pat_len         = value[4:0];
                REG_PATTERN_LOW:    pattern[63:0]   = value;
                REG_PATTERN_HIGH:   pattern[127:64] = value;
                REG_IGNORE_CASE:    fold_on         = value[0];
                REG_INVERT_MATCH:   invert_on       = value[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] to_lower(logic [7:0] c);
            if (fold_on && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
                return c + CASE_OFFSET;
            return c;
        endfunction

        // window[0] is the newest byte; it lines up with the last pattern byte
        function bit window_hit(int n);
            int k;
            for (k = 0; k < n; k++)
            begin
                if (to_lower(window[(n - 1 - k) & 15]) != to_lower(pattern[8*k +: 8]))
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void close_line(logic split, logic last);
            record_t rec;
            logic    sel;
            if (line_count != COUNT_MAX)
                line_count++;
            sel = found ^ invert_on;
            if (sel && hit_total != COUNT_MAX)
                hit_total++;
            rec                = '0;
            rec.record_kind    = KIND_LINE;
            rec.selected       = sel;
            rec.line_number    = line_count;
            rec.line_length    = (line_bytes > LEN_FIELD_MAX) ? LEN_FIELD_MAX : 10'(line_bytes);
            rec.split_by_limit = split;
            rec.is_last        = last;
            expected_records.push_back(rec);
            clear_line();
        endfunction

        function void take_input(logic cmd, logic [7:0] value);
            record_t rec;
            int      eff_len;
            int      k;
            if (cmd == CMD_DATA)
            begin
                eff_len = (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pat_len);
                for (k = 15; k > 0; k--)
                    window[k] = window[k - 1];
                window[0] = value;
                if (line_bytes < LINE_LIMIT_DEF)
                    line_bytes++;
                if (value == CHAR_NUL)
                    nul_seen = 1'b1;
                if (eff_len == 0)
                    found = 1'b1;
                else if (!nul_seen && line_bytes >= eff_len && window_hit(eff_len))
                    found = 1'b1;
                if (value == CHAR_NEWLINE || line_bytes >= LINE_LIMIT_DEF)
                    close_line(value != CHAR_NEWLINE, 1'b1);
            end
            else
            begin
                if (line_bytes > 0)
                begin
                    if (pat_len == 0)
                        found = 1'b1;
                    close_line(1'b0, 1'b0);
                end
                rec             = '0;
                rec.record_kind = KIND_COUNT;
                rec.hit_count   = hit_total;
                rec.is_last     = 1'b1;
                expected_records.push_back(rec);
                clear_line();
                line_count = '0;
                hit_total  = '0;
            end
        endfunction

        function int pending();
            return expected_records.size();
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            $display("record %0d: %s got %0h expected %0h",
                     records_checked, what, got, want);
            errors++;
        endtask

        task check_field(string what, longint unsigned got, longint unsigned want);
            if (got != want)
                report_mismatch(what, got, want);
        endtask

        task check_record(logic kind, logic [79:0] data, logic last);
            record_t want;
            records_checked++;
            if (expected_records.size() == 0)
            begin
                report_mismatch("unexpected record, data", data[63:0], 64'd0);
                return;
            end
            want = expected_records.pop_front();
            check_field("record_kind", 64'(kind), 64'(want.record_kind));
            check_field("selected", 64'(data[0]), 64'(want.selected));
            check_field("line_number", 64'(data[32:1]), 64'(want.line_number));
            check_field("line_length", 64'(data[42:33]), 64'(want.line_length));
            check_field("split_by_limit", 64'(data[43]), 64'(want.split_by_limit));
            check_field("hit_count", 64'(data[75:44]), 64'(want.hit_count));
            check_field("is_last", 64'(last), 64'(want.is_last));
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = CMD_DATA;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;

    lsf_scoreboard sb;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            items_sent     = 0;
    int            reg_writes     = 0;
    int            cycle_count    = 0;
    logic [127:0]  gen_pattern    = '0;
    int            gen_len        = 0;

    line_substring_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_record(m_tuser, m_tdata, m_tlast);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout with %0d records outstanding", sb.pending());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] value);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.take_input(cmd, value);
        items_sent++;
    endtask

    task automatic sender_rest();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drain();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic wait_quiet();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(index, value);
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_setting(input logic [4:0] len, input logic [63:0] lo,
                                 input logic [63:0] hi, input logic ic, input logic inv);
        write_reg(REG_PATTERN_LENGTH, 64'(len));
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_IGNORE_CASE, 64'(ic));
        write_reg(REG_INVERT_MATCH, 64'(inv));
        gen_pattern = {hi, lo};
        gen_len     = (len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(len);
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_item(CMD_DATA, s[i]);
    endtask

    function automatic logic [7:0] random_letter();
        int r;
        r = $urandom_range(51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [63:0] random_letters64();
        logic [63:0] w;
        int          k;
        for (k = 0; k < 8; k++)
            w[8*k +: 8] = random_letter();
        return w;
    endfunction

    function automatic logic [7:0] flip_case(logic [7:0] c);
        if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(1))
            return c ^ CASE_OFFSET;
        return c;
    endfunction

    // mostly text lines built from pattern copies, fragments and filler; some raw noise
    task automatic send_random_line();
        logic [7:0] text[$];
        int         segs;
        int         r;
        int         n;
        int         start;
        int         k;
        text = {};
        if ($urandom_range(99) < 10)
        begin
            n = $urandom_range(1, 24);
            for (k = 0; k < n; k++)
                text.push_back(8'($urandom_range(255)));
        end
        else
        begin
            segs = $urandom_range(0, 5);
            repeat (segs)
            begin
                r = $urandom_range(99);
                if (r < 30)
                begin
                    for (k = 0; k < gen_len; k++)
                        text.push_back(flip_case(gen_pattern[8*k +: 8]));
                end
                else if (r < 45 && gen_len > 1)
                begin
                    n     = $urandom_range(1, gen_len - 1);
                    start = $urandom_range(0, gen_len - n);
                    for (k = start; k < start + n; k++)
                        text.push_back(gen_pattern[8*k +: 8]);
                end
                else if (r < 92)
                begin
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++)
                        text.push_back(($urandom_range(7) == 0) ? 8'(" ") : random_letter());
                end
                else
                begin
                    text.push_back(8'($urandom_range(255)));
                end
            end
        end
        foreach (text[i])
            send_item(CMD_DATA, text[i]);
        r = $urandom_range(99);
        if (r < 85)
        begin
            send_item(CMD_DATA, CHAR_NEWLINE);
        end
        else if (r < 93)
        begin
            send_item(CMD_EOF, 8'($urandom_range(255)));
        end
        else
        begin
            send_item(CMD_DATA, CHAR_NEWLINE);
            send_item(CMD_EOF, 8'($urandom_range(255)));
        end
    endtask

    // a line of exactly the limit, closed either by the limit or by a newline on its last byte
    task automatic send_long_line(input bit newline_last);
        logic [7:0] c;
        int         k;
        for (k = 0; k < LINE_LIMIT_DEF - 1; k++)
        begin
            c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : random_letter();
            if (c == CHAR_NEWLINE)
                c = "x";
            send_item(CMD_DATA, c);
        end
        send_item(CMD_DATA, newline_last ? CHAR_NEWLINE : random_letter());
    endtask

    initial
    begin
        logic [4:0]  len;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        ic;
        logic        inv;
        int          phase;
        int          phase_start;
        int          pause_at;
        bit          paused;

        sb = new();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // pattern "abc", case folded
        apply_setting(5'd3, 64'h0000_0000_0063_6261, 64'h0, 1'b1, 1'b0);
        send_text("xABc\n");
        send_item(CMD_DATA, "a");
        send_item(CMD_DATA, CHAR_NUL);
        send_text("abc\n");
        send_item(CMD_DATA, 8'hFF);
        send_item(CMD_DATA, CHAR_NEWLINE);
        send_item(CMD_DATA, CHAR_NEWLINE);
        send_text("abc");
        send_item(CMD_EOF, 8'hFF);
        send_item(CMD_EOF, 8'h00);

        for (phase = 0; phase < PHASES; phase++)
        begin
            sender_rest();
            wait_quiet();
            unique case (phase)
                0:
                begin
                    len = 5'd1;  lo = random_letters64(); hi = random_letters64();
                    ic = 1'b0; inv = 1'b0;
                end
                1:
                begin
                    len = 5'd16; lo = random_letters64(); hi = random_letters64();
                    ic = 1'b1; inv = 1'b1;
                end
                2:
                begin
                    len = 5'd0;  lo = random_letters64(); hi = '1;
                    ic = 1'b0; inv = 1'b0;
                end
                3:
                begin
                    len = 5'd31; lo = '1; hi = '1;
                    ic = 1'b1; inv = 1'b0;
                end
                4:
                begin
                    len = 5'd4;  lo = random_letters64(); hi = random_letters64();
                    lo[15:8] = CHAR_NUL;
                    ic = 1'b0; inv = 1'b1;
                end
                5:
                begin
                    len = 5'($urandom_range(1, 16));
                    lo = random_letters64(); hi = random_letters64();
                    ic = 1'($urandom_range(1)); inv = 1'($urandom_range(1));
                end
                6:
                begin
                    len = 5'd0;  lo = '0; hi = '0;
                    ic = 1'b1; inv = 1'b1;
                end
                default:
                begin
                    len = 5'($urandom_range(31));
                    lo = {$urandom, $urandom}; hi = {$urandom, $urandom};
                    ic = 1'($urandom_range(1)); inv = 1'($urandom_range(1));
                end
            endcase
            apply_setting(len, lo, hi, ic, inv);

            unique case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase

            if (phase == 2)
                send_long_line(1'b0);

            phase_start = items_sent;
            pause_at    = $urandom_range(5, PHASE_ITEMS - 5);
            paused      = 1'b0;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                send_random_line();
                if (!paused && items_sent - phase_start >= pause_at)
                begin
                    sender_rest();
                    wait_drain();
                    paused = 1'b1;
                end
            end
        end

        sender_rest();
        wait_quiet();
        $display("run covered %0d byte/eof transactions, %0d records checked,",
                 items_sent, sb.records_checked);
        $display("%0d register writes over %0d settings incl. a limit-length line",
                 reg_writes, PHASES + 1);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
